[design/gbsl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gbsl_pkg;

  localparam int NUM_GROUPS_DEF = 16;
  localparam int MAX_FACES_DEF  = 65535;

  localparam int ADDR_W      = 18;
  localparam int DATA_W      = 32;
  localparam int MAT_W       = 16;
  localparam int Z_W         = 32;
  localparam int TALLY_W     = 16;
  localparam int GCOUNT_W    = 5;
  localparam int GROUP_IDX_W = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_CUR_MAT = 1'b0;

  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_COUNT  = 2'd1,
    REQ_LAYOUT = 2'd2,
    REQ_PLACE  = 2'd3
  } req_e;

  typedef struct packed {
    req_e                   req_type;
    logic [MAT_W-1:0]       material_id;
    logic signed [Z_W-1:0]  z_first;
    logic signed [Z_W-1:0]  z_second;
    logic signed [Z_W-1:0]  z_third;
    logic [DATA_W-1:0]      vert_a;
    logic [DATA_W-1:0]      vert_b;
    logic [DATA_W-1:0]      vert_c;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   write_address;
    logic [DATA_W-1:0]   write_data;
    logic                last;
    logic [ADDR_W-1:0]   total_words;
    logic [GCOUNT_W-1:0] group_count;
  } res_t;

  typedef struct packed {
    req_e                   req_type;
    logic                   match;
    logic [GROUP_IDX_W-1:0] group;
    logic [DATA_W-1:0]      vert_a;
    logic [DATA_W-1:0]      vert_b;
    logic [DATA_W-1:0]      vert_c;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

[design/gbsl_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module gbsl_queue (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  gbsl_pkg::entry_t       entry_i,
  input  wire                    pop_i,
  output gbsl_pkg::entry_t       head_o,
  output gbsl_pkg::queue_status_t status_o
);

  localparam int PtrW = $clog2(gbsl_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(gbsl_pkg::QUEUE_DEPTH + 1);

  gbsl_pkg::entry_t mem_q [gbsl_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  assign head_o         = mem_q[rd_q];
  assign status_o.full  = (cnt_q == CntW'(gbsl_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

[design/gbsl_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module gbsl_front #(
  parameter int NUM_GROUPS = gbsl_pkg::NUM_GROUPS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  gbsl_pkg::req_t               req_i,
  input  wire [gbsl_pkg::MAT_W-1:0]    cur_mat_i,
  input  gbsl_pkg::queue_status_t      qstat_i,
  output logic                         push_o,
  output gbsl_pkg::entry_t             entry_o
);

  localparam int GW    = $clog2(NUM_GROUPS);
  localparam int MulW  = gbsl_pkg::Z_W + 7;
  localparam int LvlW  = MulW - 16 + 1;
  localparam logic [15:0] FracCarryMin = 16'd65471;
  localparam logic signed [LvlW-1:0] GroupTop = LvlW'(NUM_GROUPS - 1);

  // Level of one channel: trunc(z*100 + 0.001) with z in Q16.16. The bias of
  // 0.001 carries into the integer part once the fraction reaches 65471/65536,
  // and the exact sum is never an integer, so a negative floor rounds up by one.
  function automatic logic signed [LvlW-1:0] chan_level(input logic signed [gbsl_pkg::Z_W-1:0] z);
    logic signed [MulW-1:0] zx;
    logic signed [MulW-1:0] w;
    logic signed [LvlW-1:0] fl;
    logic                   up;
    zx = MulW'(z);
    w  = (zx <<< 6) + (zx <<< 5) + (zx <<< 2);
    up = (w[15:0] >= FracCarryMin);
    fl = LvlW'($signed(w[MulW-1:16])) + LvlW'(up);
    return fl + LvlW'(fl[LvlW-1]);
  endfunction

  logic                   stg_valid_q, stg_valid_d;
  gbsl_pkg::req_t         stg_q;
  logic                   accept;
  logic signed [LvlW-1:0] lvl0, lvl1, lvl2;
  logic [GW-1:0]          group;

  assign busy   = stg_valid_q && qstat_i.full;
  assign accept = start && !busy;
  assign push_o = stg_valid_q && !qstat_i.full;

  always_comb begin
    lvl0 = chan_level(stg_q.z_first);
    lvl1 = chan_level(stg_q.z_second);
    lvl2 = chan_level(stg_q.z_third);
    if ((lvl0 != lvl1) || (lvl0 != lvl2) || lvl0[LvlW-1]) begin
      group = '0;
    end else if (lvl0 > GroupTop) begin
      group = GW'(NUM_GROUPS - 1);
    end else begin
      group = lvl0[GW-1:0];
    end
  end

  always_comb begin
    entry_o.req_type = stg_q.req_type;
    entry_o.match    = (stg_q.material_id == cur_mat_i);
    entry_o.group    = gbsl_pkg::GROUP_IDX_W'(group);
    entry_o.vert_a   = stg_q.vert_a;
    entry_o.vert_b   = stg_q.vert_b;
    entry_o.vert_c   = stg_q.vert_c;
  end

  always_comb begin
    if (accept) begin
      stg_valid_d = 1'b1;
    end else if (push_o) begin
      stg_valid_d = 1'b0;
    end else begin
      stg_valid_d = stg_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q <= req_i;
    end
  end

endmodule

`default_nettype wire

[design/gbsl_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module gbsl_back #(
  parameter int NUM_GROUPS = gbsl_pkg::NUM_GROUPS_DEF,
  parameter int MAX_FACES  = gbsl_pkg::MAX_FACES_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  gbsl_pkg::entry_t         head_i,
  input  gbsl_pkg::queue_status_t  qstat_i,
  output logic                     pop_o,
  output logic                     strobe_o,
  output gbsl_pkg::res_t           res_o
);

  localparam int AW      = gbsl_pkg::ADDR_W;
  localparam int TW      = gbsl_pkg::TALLY_W;
  localparam int GW      = $clog2(NUM_GROUPS);
  localparam int SumMax  = NUM_GROUPS * (MAX_FACES * 3 + 2);
  localparam int SumBits = $clog2(SumMax + 1);
  localparam int SumW    = (SumBits > AW) ? SumBits : AW + 1;
  localparam int CntW    = $clog2(NUM_GROUPS + 1);
  localparam logic [GW-1:0] IdxLast = GW'(NUM_GROUPS - 1);
  localparam logic [1:0]    KLast   = 2'd2;

  typedef enum logic [1:0] {
    StIdle,
    StLayout,
    StPlace
  } state_e;

  state_e                state_q, state_d;
  logic [GW-1:0]         idx_q, idx_d;
  logic                  phase_q, phase_d;
  logic [AW-1:0]         head_q, head_d;
  logic [1:0]            k_q, k_d;
  gbsl_pkg::entry_t      ent_q, ent_d;
  logic [TW-1:0]         tally_q [NUM_GROUPS];
  logic [TW-1:0]         tally_d [NUM_GROUPS];
  logic [AW-1:0]         whead_q [NUM_GROUPS];
  logic [AW-1:0]         whead_d [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] nz_q, nz_d;
  logic [SumW-1:0]       sum_q, sum_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  strobe_q, strobe_d;
  gbsl_pkg::res_t        res_q, res_d;

  logic [GW-1:0]         rd_idx;
  logic [GW-1:0]         place_idx;
  logic [TW-1:0]         tally_rd;
  logic [AW-1:0]         whead_rd;
  logic [AW-1:0]         len;
  logic                  later_any;

  always_comb begin
    rd_idx    = (state_q == StIdle) ? head_i.group[GW-1:0] : idx_q;
    place_idx = ent_q.group[GW-1:0];
    tally_rd  = tally_q[rd_idx];
    whead_rd  = whead_q[place_idx];
    len       = AW'(tally_rd) * AW'(3);
    later_any = 1'b0;
    for (int j = 0; j < NUM_GROUPS; j++) begin
      if (nz_q[j] && (idx_q < GW'(j))) begin
        later_any = 1'b1;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    phase_d  = phase_q;
    head_d   = head_q;
    k_d      = k_q;
    ent_d    = ent_q;
    tally_d  = tally_q;
    whead_d  = whead_q;
    nz_d     = nz_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    pop_o    = 1'b0;

    res_d.total_words = (sum_q > SumW'(gbsl_pkg::ADDR_MAX)) ? gbsl_pkg::ADDR_MAX
                                                             : sum_q[AW-1:0];
    res_d.group_count = gbsl_pkg::GCOUNT_W'(cnt_q);

    case (state_q)
      StIdle: begin
        if (!qstat_i.empty) begin
          pop_o = 1'b1;
          ent_d = head_i;
          case (head_i.req_type)
            gbsl_pkg::REQ_CLEAR: begin
              for (int g = 0; g < NUM_GROUPS; g++) begin
                tally_d[g] = '0;
                whead_d[g] = '0;
              end
              nz_d  = '0;
              sum_d = '0;
              cnt_d = '0;
            end
            gbsl_pkg::REQ_COUNT: begin
              if (head_i.match && (tally_rd < TW'(MAX_FACES))) begin
                tally_d[rd_idx] = tally_rd + TW'(1);
                nz_d[rd_idx]    = 1'b1;
                if (tally_rd == '0) begin
                  sum_d = sum_q + SumW'(5);
                  cnt_d = cnt_q + CntW'(1);
                end else begin
                  sum_d = sum_q + SumW'(3);
                end
              end
            end
            gbsl_pkg::REQ_LAYOUT: begin
              idx_d   = '0;
              phase_d = 1'b0;
              head_d  = '0;
              state_d = StLayout;
            end
            gbsl_pkg::REQ_PLACE: begin
              if (head_i.match) begin
                k_d     = '0;
                state_d = StPlace;
              end
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      StLayout: begin
        if (!phase_q) begin
          if (nz_q[idx_q]) begin
            strobe_d            = 1'b1;
            res_d.write_address = head_q;
            res_d.write_data    = gbsl_pkg::DATA_W'(idx_q);
            res_d.last          = 1'b0;
            phase_d             = 1'b1;
          end else if (idx_q == IdxLast) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q + GW'(1);
          end
        end else begin
          strobe_d            = 1'b1;
          res_d.write_address = head_q + AW'(1);
          res_d.write_data    = gbsl_pkg::DATA_W'(len);
          res_d.last          = !later_any;
          whead_d[idx_q]      = head_q + AW'(2);
          head_d              = head_q + len + AW'(2);
          phase_d             = 1'b0;
          if (!later_any) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q + GW'(1);
          end
        end
      end
      StPlace: begin
        strobe_d            = 1'b1;
        res_d.write_address = whead_rd + AW'(k_q);
        res_d.last          = (k_q == KLast);
        case (k_q)
          2'd0:    res_d.write_data = ent_q.vert_a;
          2'd1:    res_d.write_data = ent_q.vert_b;
          default: res_d.write_data = ent_q.vert_c;
        endcase
        if (k_q == KLast) begin
          whead_d[place_idx] = whead_rd + AW'(3);
          state_d            = StIdle;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      idx_q    <= '0;
      phase_q  <= 1'b0;
      head_q   <= '0;
      k_q      <= '0;
      nz_q     <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        tally_q[g] <= '0;
        whead_q[g] <= '0;
      end
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      phase_q  <= phase_d;
      head_q   <= head_d;
      k_q      <= k_d;
      nz_q     <= nz_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
      tally_q  <= tally_d;
      whead_q  <= whead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    res_q <= res_d;
  end

  assign strobe_o = strobe_q;
  assign res_o    = res_q;

endmodule

`default_nettype wire

[design/group_bucket_scatter_layout.sv]
`timescale 1ns / 1ps
`default_nettype none

// Counting-sort layout engine for triangle faces. A request is taken when start is high and
// busy is low; a front stage registers it, works out its material match and group, and
// passes it through a two-entry queue to a sequencer that owns the tally and head tables.
// The sequencer handles one request at a time: clear and count give no writes, a place of
// a matching face gives three buffer writes, and a layout walks the groups in order
// and gives two writes, group index then length, for each non-empty group, ending at
// the last non-empty group. Each write appears for one cycle with result_strobe_o high
// and cannot be held off, so the receiver must take every transfer as it comes; busy only
// rises when the front stage and the queue are both full. Write current_material only while
// no request is in flight.
module group_bucket_scatter_layout #(
  parameter int NUM_GROUPS = gbsl_pkg::NUM_GROUPS_DEF,
  parameter int MAX_FACES  = gbsl_pkg::MAX_FACES_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start,
  output logic                          busy,
  input  gbsl_pkg::req_t                req_i,
  output logic                          result_strobe_o,
  output gbsl_pkg::res_t                res_o,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire [gbsl_pkg::PADDR_W-1:0]   paddr,
  input  wire [gbsl_pkg::PDATA_W-1:0]   pwdata,
  output logic [gbsl_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic [gbsl_pkg::MAT_W-1:0] cur_mat_q, cur_mat_d;
  logic                       cfg_wr;
  logic                       q_push;
  logic                       q_pop;
  gbsl_pkg::entry_t           q_in;
  gbsl_pkg::entry_t           q_head;
  gbsl_pkg::queue_status_t    qstat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == gbsl_pkg::REG_CUR_MAT);
  assign cur_mat_d = cfg_wr ? pwdata[gbsl_pkg::MAT_W-1:0] : cur_mat_q;
  assign prdata = (paddr[2] == gbsl_pkg::REG_CUR_MAT) ? gbsl_pkg::PDATA_W'(cur_mat_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mat_q <= '0;
    end else begin
      cur_mat_q <= cur_mat_d;
    end
  end

  gbsl_front #(
    .NUM_GROUPS(NUM_GROUPS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .req_i    (req_i),
    .cur_mat_i(cur_mat_q),
    .qstat_i  (qstat),
    .push_o   (q_push),
    .entry_o  (q_in)
  );

  gbsl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .status_o(qstat)
  );

  gbsl_back #(
    .NUM_GROUPS(NUM_GROUPS),
    .MAX_FACES (MAX_FACES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (q_head),
    .qstat_i (qstat),
    .pop_o   (q_pop),
    .strobe_o(result_strobe_o),
    .res_o   (res_o)
  );

  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && qstat.full))
    else $error("queue written while full");

  a_queue_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && qstat.empty))
    else $error("queue read while empty");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && res_o.last) |=> !result_strobe_o)
    else $error("transfer directly after the final transfer of a request");

endmodule

`default_nettype wire
